// ----- hw/rtl/bpa_pkg.sv -----
// Shared types, codes and helpers for the bitmap page allocator.
// Used by bpa_ctrl, bpa_datapath and bitmap_page_allocator_core; depends on nothing.
package bpa_pkg;

    // Defaults for the top-level parameters
    localparam int BPA_WORDS      = 512;
    localparam int BPA_PAGE_SHIFT = 12;

    // Fixed field widths
    localparam int ADDR_W       = 48;
    localparam int CNT_W        = 16;
    localparam int POOL_WORDS_W = 10;
    localparam int STATUS_W     = 2;
    localparam int WORD_BITS    = 64;
    localparam int BIT_IDX_W    = 6;
    localparam int CFG_IDX_W    = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd3;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_WORDS = 2'd1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] page_address;
    } bpa_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   alloc_address;
        logic [CNT_W-1:0]    pages_in_use;
        logic [CNT_W-1:0]    pages_left;
    } bpa_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic                load_item;
        logic                clear_start;
        logic                clear_step;
        logic                scan_start;
        logic                scan_en;
        logic                free_check;
        logic                free_update;
        logic                status_we;
        logic [STATUS_W-1:0] status;
        logic                result_load;
    } bpa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cfg_clear;
        logic clear_last;
        logic words_zero;
        logic scan_hit;
        logic scan_miss_last;
        logic free_in_range;
        logic free_bit_set;
        logic rsp_busy;
    } bpa_stat_t;

    // Index of the lowest clear bit; 63 when the word is all ones
    function automatic logic [BIT_IDX_W-1:0] bpa_first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_IDX_W-1:0] r;
        r = BIT_IDX_W'(WORD_BITS - 1);
        for (int n = WORD_BITS - 1; n >= 0; n--)
        begin
            if (!w[n])
            begin
                r = BIT_IDX_W'(n);
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/bpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/bpa_ctrl.sv -----
// Sequencer for the page allocator: clear pass, alloc scan, free check, result.
// Depends on bpa_pkg; drives bpa_datapath through bpa_cmd_t.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_op,
    output logic      req_stall,
    input  bpa_stat_t stat,
    output bpa_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FCHK  = 3'd3;
    localparam logic [2:0] S_FUPD  = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    // Requests are taken only in idle, never alongside a pool restart
    assign req_stall = (state_reg != S_IDLE) || stat.cfg_clear;
    assign accept    = req_valid && !req_stall;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    if (req_op == OP_FREE)
                    begin
                        state_next = S_FCHK;
                    end
                    else if (stat.words_zero)
                    begin
                        cmd.status_we = 1'b1;
                        cmd.status    = ST_FULL;
                        state_next    = S_RES;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.scan_hit)
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = ST_OK;
                    state_next    = S_RES;
                end
                else if (stat.scan_miss_last)
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = ST_FULL;
                    state_next    = S_RES;
                end
            end
            S_FCHK:
            begin
                cmd.free_check = 1'b1;
                if (stat.free_in_range)
                begin
                    state_next = S_FUPD;
                end
                else
                begin
                    cmd.status_we = 1'b1;
                    cmd.status    = ST_RANGE;
                    state_next    = S_RES;
                end
            end
            S_FUPD:
            begin
                cmd.free_update = 1'b1;
                cmd.status_we   = 1'b1;
                cmd.status      = stat.free_bit_set ? ST_OK : ST_DOUBLE;
                state_next      = S_RES;
            end
            S_RES:
            begin
                if (!stat.rsp_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // A pool register write restarts the clearing pass from any state
        if (stat.cfg_clear)
        begin
            cmd.clear_start = 1'b1;
            state_next      = S_CLEAR;
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted request always moves into work
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN || state_reg == S_FCHK || state_reg == S_RES))
        else $error("accepted request did not start work");

    // Free update only follows a range check
    a_fupd_after_fchk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FUPD) |-> ($past(state_reg) == S_FCHK))
        else $error("free update without range check");

    // No request is taken while the bitmap is being cleared
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> req_stall)
        else $error("request accepted during clear pass");

endmodule

// ----- hw/rtl/bpa_datapath.sv -----
// Datapath of the page allocator: pool registers, bitmap RAM, scan pointer,
// free range check, counters and the response register. Depends on bpa_pkg, bpa_ram.
module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int WORDS      = BPA_WORDS,
    parameter int PAGE_SHIFT = BPA_PAGE_SHIFT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpa_req_t             req,
    output bpa_rsp_t             rsp,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  bpa_cmd_t             cmd,
    output bpa_stat_t            stat
);

    localparam int WIDX   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WCNT_W = $clog2(WORDS + 1);
    localparam int WIU_W  = (WCNT_W < POOL_WORDS_W) ? WCNT_W : POOL_WORDS_W;
    localparam int CW     = (WCNT_W > POOL_WORDS_W) ? WCNT_W : POOL_WORDS_W;
    localparam int SH     = PAGE_SHIFT + BIT_IDX_W;

    // Pool registers
    logic [ADDR_W-1:0]       pool_base_reg;
    logic [POOL_WORDS_W-1:0] pool_words_reg;
    logic                    cfg_base_we;
    logic                    cfg_words_we;

    // Request and allocator state
    logic                    op_reg;
    logic [ADDR_W-1:0]       req_addr_reg;
    logic [WIDX-1:0]         next_word_reg;
    logic [CNT_W-1:0]        used_reg;
    logic [STATUS_W-1:0]     status_reg;

    // Scan and clear
    logic [WIDX-1:0]         clr_ptr_reg;
    logic [WIDX-1:0]         ptr_reg;
    logic [WIDX-1:0]         dptr_reg;
    logic [WCNT_W-1:0]       ecnt_reg;
    logic                    rvalid_reg;
    logic [WIDX-1:0]         hit_idx_reg;
    logic [BIT_IDX_W-1:0]    hit_bit_reg;
    logic [WIDX-1:0]         fidx_reg;
    logic [BIT_IDX_W-1:0]    fbit_reg;

    // Response register
    bpa_rsp_t                rsp_reg;
    logic                    rsp_valid_reg;

    // Derived values
    logic [CW-1:0]           pw_ext;
    logic [WIU_W-1:0]        words;
    logic [WCNT_W-1:0]       words_x;
    logic [WIDX-1:0]         scan_start_idx;
    logic [WIDX-1:0]         ptr_wrap;
    logic                    any_free;
    logic [BIT_IDX_W-1:0]    free_bit;
    logic                    hit;
    logic [ADDR_W-1:0]       foff;
    logic [ADDR_W-1:0]       pool_size;
    logic                    in_range;
    logic [WIDX-1:0]         fidx;
    logic                    bit_set;
    logic                    free_we;
    logic [CNT_W-1:0]        total;
    logic [CNT_W-1:0]        free_cnt;
    logic [ADDR_W-1:0]       alloc_off;
    logic [ADDR_W-1:0]       alloc_addr;

    // RAM ports
    logic                    ram_we;
    logic [WIDX-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]    ram_wdata;
    logic [WIDX-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]    ram_rdata;

    assign cfg_ready    = 1'b1;
    assign cfg_base_we  = cfg_valid && (cfg_index == CFG_POOL_BASE);
    assign cfg_words_we = cfg_valid && (cfg_index == CFG_POOL_WORDS);

    // Words in use: pool_words capped at the bitmap depth
    assign pw_ext  = CW'(pool_words_reg);
    assign words   = (pw_ext > CW'(WORDS)) ? WIU_W'(CW'(WORDS)) : WIU_W'(pw_ext);
    assign words_x = WCNT_W'(words);

    // Stale hint restarts at word 0; pointer wraps at the last word in use
    assign scan_start_idx = (WCNT_W'(next_word_reg) < words_x) ? next_word_reg : '0;
    assign ptr_wrap       = ((WCNT_W'(ptr_reg) + 1'b1) == words_x) ? '0 : ptr_reg + 1'b1;

    // Word returning from the RAM during a scan
    assign any_free = ~&ram_rdata;
    assign free_bit = bpa_first_zero(ram_rdata);
    assign hit      = cmd.scan_en && rvalid_reg && any_free;

    // Free range check
    assign foff      = req_addr_reg - pool_base_reg;
    assign pool_size = ADDR_W'(words) << SH;
    assign in_range  = foff < pool_size;
    assign fidx      = foff[SH +: WIDX];
    assign bit_set   = ram_rdata[fbit_reg];
    assign free_we   = cmd.free_update && bit_set;

    // Counts and allocated address
    assign total      = CNT_W'({words, {BIT_IDX_W{1'b0}}});
    assign free_cnt   = (total >= used_reg) ? total - used_reg : '0;
    assign alloc_off  = ADDR_W'({hit_idx_reg, hit_bit_reg}) << PAGE_SHIFT;
    assign alloc_addr = pool_base_reg + alloc_off;

    // RAM port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_ptr_reg;
        ram_wdata = '0;
        if (cmd.clear_step)
        begin
            ram_we = 1'b1;
        end
        else if (hit)
        begin
            ram_we    = 1'b1;
            ram_waddr = dptr_reg;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << free_bit);
        end
        else if (free_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = fidx_reg;
            ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fbit_reg);
        end
        ram_raddr = cmd.scan_en ? ptr_reg : fidx;
    end

    bpa_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(WORDS)
    ) u_bitmap (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Pool registers, hint and used count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= '0;
            pool_words_reg <= '0;
            next_word_reg  <= '0;
            used_reg       <= '0;
        end
        else
        begin
            if (cfg_base_we)
            begin
                pool_base_reg <= cfg_data;
            end
            if (cfg_words_we)
            begin
                pool_words_reg <= cfg_data[POOL_WORDS_W-1:0];
            end
            if (cfg_base_we || cfg_words_we)
            begin
                next_word_reg <= '0;
                used_reg      <= '0;
            end
            else if (hit)
            begin
                next_word_reg <= dptr_reg;
                used_reg      <= used_reg + 1'b1;
            end
            else if (free_we)
            begin
                used_reg <= used_reg - 1'b1;
            end
        end
    end

    // Scan and clear control registers and the response valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg   <= '0;
            rvalid_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_start)
            begin
                clr_ptr_reg <= '0;
            end
            else if (cmd.clear_step)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end
            rvalid_reg <= cmd.scan_en;
            if (cmd.result_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg       <= req.op;
            req_addr_reg <= req.page_address;
        end
        if (cmd.scan_start)
        begin
            ptr_reg  <= scan_start_idx;
            ecnt_reg <= '0;
        end
        else if (cmd.scan_en)
        begin
            ptr_reg <= ptr_wrap;
            if (rvalid_reg)
            begin
                ecnt_reg <= ecnt_reg + 1'b1;
            end
        end
        dptr_reg <= ptr_reg;
        if (hit)
        begin
            hit_idx_reg <= dptr_reg;
            hit_bit_reg <= free_bit;
        end
        if (cmd.free_check)
        begin
            fidx_reg <= fidx;
            fbit_reg <= foff[PAGE_SHIFT +: BIT_IDX_W];
        end
        if (cmd.status_we)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.result_load)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.alloc_address <= (status_reg == ST_OK && op_reg == OP_ALLOC) ?
                                     alloc_addr : '0;
            rsp_reg.pages_in_use  <= used_reg;
            rsp_reg.pages_left    <= free_cnt;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // Status to the controller
    assign stat.cfg_clear      = cfg_base_we || cfg_words_we;
    assign stat.clear_last     = (clr_ptr_reg == WIDX'(WORDS - 1));
    assign stat.words_zero     = (words == '0);
    assign stat.scan_hit       = hit;
    assign stat.scan_miss_last = rvalid_reg && !any_free
                                 && ((ecnt_reg + 1'b1) == words_x);
    assign stat.free_in_range  = in_range;
    assign stat.free_bit_set   = bit_set;
    assign stat.rsp_busy       = rsp_valid_reg && rsp_stall;

    // Used pages never exceed the pool
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= total)
        else $error("used count exceeds pool size");

    // Hint stays inside the pool once set
    a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (WCNT_W'(next_word_reg) < words_x) || (next_word_reg == '0))
        else $error("next-fit hint outside pool");

    // A bit is cleared only for an address that passed the range check
    a_free_checked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_update |-> ($past(cmd.free_check) && $past(in_range)))
        else $error("free update without in-range check");

endmodule

// ----- hw/rtl/bitmap_page_allocator_core.sv -----
// Bitmap page allocator, next-fit. Free: range check, bitmap read/update, then result;
// an address outside the pool skips the bitmap step and goes straight to the result.
// Alloc: the scan reads one RAM word per cycle from the next-fit hint, wrapping at the
// last word in use, until a clear bit or a full pass; a pool of zero words answers FULL without a scan.
// One request in work at a time; the next is taken in the cycle after the response loads.
// Reset and each pool register write clear the whole bitmap; requests stall.
module bitmap_page_allocator_core
    import bpa_pkg::*;
#(
    parameter int WORDS      = BPA_WORDS,
    parameter int PAGE_SHIFT = BPA_PAGE_SHIFT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  bpa_req_t             req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output bpa_rsp_t             rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_op   (req.op),
        .req_stall(req_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpa_datapath #(
        .WORDS     (WORDS),
        .PAGE_SHIFT(PAGE_SHIFT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
